// ----- sv/battery_pack_cell_monitor_core_assert.svh -----
// assertion macros shared by the cell monitor checkers
`ifndef BATTERY_PACK_CELL_MONITOR_CORE_ASSERT_SVH
`define BATTERY_PACK_CELL_MONITOR_CORE_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define BPCM_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bpcm: same-cycle check failed");

// next-cycle implication, off while reset is asserted
`define BPCM_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bpcm: next-cycle check failed");

`endif

// ----- sv/bpcm_pkg.sv -----
// types, constants and codes shared by the cell monitor modules
package bpcm_pkg;

  // pack total accumulator width
  localparam int TOTAL_W = 24;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // queue between front and back
  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);

  // code to millivolt conversion: floor(code * 19073 / 100000)
  localparam logic [14:0] VOLT_MUL    = 15'd19073;
  // reciprocal of 100000 scaled by 2^47, rounded up; exact for 30-bit products
  localparam logic [30:0] RECIP_MUL   = 31'd1407374884;
  localparam int          RECIP_SHIFT = 47;

  // voltage window and clear values
  localparam logic [12:0] MV_CELL_LO  = 13'd1000;
  localparam logic [12:0] MV_CELL_HI  = 13'd5000;
  localparam logic [12:0] MV_MIN_CLR  = 13'd5000;
  localparam logic [12:0] MV_UV_FLOOR = 13'd500;

  // temperature window and clear values, tenths of a degree
  localparam logic signed [15:0] TEMP_LO      = -16'sd1000;
  localparam logic signed [15:0] TEMP_HI      = 16'sd2000;
  localparam logic signed [15:0] TEMP_MIN_CLR = 16'sd20000;
  localparam logic signed [15:0] TEMP_MAX_CLR = -16'sd20000;

  // threshold reset values (temperatures already scaled by ten)
  localparam logic [12:0]        OV_MV_RST  = 13'd4200;
  localparam logic [12:0]        UV_MV_RST  = 13'd3000;
  localparam logic signed [15:0] OT_X10_RST = 16'sd600;
  localparam logic signed [15:0] UT_X10_RST = 16'sd0;

  typedef enum logic [1:0] {
    ACT_CLR_VOLT = 2'd0,
    ACT_VOLT     = 2'd1,
    ACT_CLR_TEMP = 2'd2,
    ACT_TEMP     = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OV_MV  = 2'd0,
    CFG_UV_MV  = 2'd1,
    CFG_OT_DEG = 2'd2,
    CFG_UT_DEG = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    action_t            action;
    logic signed [15:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [12:0]        cell_mv;
    logic               sample_valid;
    logic [23:0]        pack_total_mv;
    logic [12:0]        lowest_cell_mv;
    logic [12:0]        highest_cell_mv;
    logic signed [15:0] lowest_temp;
    logic signed [15:0] highest_temp;
    logic               over_voltage_fault;
    logic               under_voltage_fault;
    logic               over_temp_fault;
    logic               under_temp_fault;
  } out_word_t;

  // classified word from front to back
  typedef struct packed {
    action_t            op;
    logic               ok;
    logic [12:0]        mv;
    logic signed [15:0] temp;
  } mid_word_t;

  // fault thresholds as seen by the back end
  typedef struct packed {
    logic [12:0]        ov_mv;
    logic [12:0]        uv_mv;
    logic signed [15:0] ot_x10;
    logic signed [15:0] ut_x10;
  } thr_t;

endpackage

// ----- sv/bpcm_fifo.sv -----
// small queue of classified words between front and back
module bpcm_fifo
  import bpcm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mid_word_t wdata,
  output logic      full,
  input  logic      pop,
  output mid_word_t rdata,
  output logic      empty
);

  mid_word_t            mem_r [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [MID_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [MID_PTR_W:0]   cnt_r, cnt_nxt;
  logic                 push_ok, pop_ok;

  assign full    = (cnt_r == (MID_PTR_W+1)'(MID_DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- sv/bpcm_front.sv -----
// front end: accepts words, converts voltage codes, classifies samples
module bpcm_front
  import bpcm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_word_t  in_word,
  output logic      in_full,
  output logic      mid_push,
  output mid_word_t mid_word,
  input  logic      mid_full
);

  logic               s1_v_r, s1_v_nxt;
  action_t            s1_act_r;
  logic signed [15:0] s1_samp_r;
  logic [29:0]        s1_prod_r;
  logic [29:0]        s1_prod_nxt;

  logic               s2_v_r, s2_v_nxt;
  action_t            s2_act_r;
  logic signed [15:0] s2_samp_r;
  logic [12:0]        s2_mv_r;
  logic [60:0]        quot_full;

  logic               accept, s2_free, s1_load_s2;
  logic               neg;
  logic [12:0]        volt_mv;

  // stage handshake: stage 2 drains into the queue, stage 1 into stage 2
  assign mid_push   = s2_v_r && !mid_full;
  assign s2_free    = !s2_v_r || !mid_full;
  assign in_full    = s1_v_r && !s2_free;
  assign accept     = in_push && !in_full;
  assign s1_load_s2 = s1_v_r && s2_free;

  assign s1_v_nxt = accept || (s1_v_r && !s2_free);
  assign s2_v_nxt = s2_free ? s1_v_r : 1'b1;

  // first multiply: code times the millivolt scale
  assign s1_prod_nxt = 30'(in_word.sample[14:0]) * 30'(VOLT_MUL);

  // second multiply: divide by 100000 through the scaled reciprocal
  assign quot_full = 61'(s1_prod_r) * 61'(RECIP_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act_r  <= in_word.action;
      s1_samp_r <= in_word.sample;
      s1_prod_r <= s1_prod_nxt;
    end
    if (s1_load_s2) begin
      s2_act_r  <= s1_act_r;
      s2_samp_r <= s1_samp_r;
      s2_mv_r   <= quot_full[RECIP_SHIFT+12:RECIP_SHIFT];
    end
  end

  // classification against the validity windows
  assign neg     = s2_samp_r[15];
  assign volt_mv = neg ? '0 : s2_mv_r;

  always_comb begin
    mid_word.op   = s2_act_r;
    mid_word.temp = s2_samp_r;
    mid_word.mv   = '0;
    mid_word.ok   = 1'b0;
    unique case (s2_act_r)
      ACT_VOLT: begin
        mid_word.mv = volt_mv;
        mid_word.ok = !neg && (volt_mv >= MV_CELL_LO) && (volt_mv <= MV_CELL_HI);
      end
      ACT_TEMP: begin
        mid_word.ok = (s2_samp_r >= TEMP_LO) && (s2_samp_r <= TEMP_HI);
      end
      default: begin
        mid_word.ok = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/bpcm_back.sv -----
// back end: scan statistics, fault flags and the result buffer
module bpcm_back
  import bpcm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      mid_empty,
  input  mid_word_t mid_word,
  output logic      mid_pop,
  input  thr_t      thr,
  output logic      out_empty,
  input  logic      out_pop,
  output out_word_t out_word
);

  logic [TOTAL_W-1:0] tot_r, tot_nxt, tot_upd;
  logic [12:0]        min_mv_r, min_mv_nxt, min_mv_upd;
  logic [12:0]        max_mv_r, max_mv_nxt, max_mv_upd;
  logic signed [15:0] min_t_r, min_t_nxt, min_t_upd;
  logic signed [15:0] max_t_r, max_t_nxt, max_t_upd;
  logic [TOTAL_W:0]   sum;

  logic signed [15:0] ot_x10, ut_x10;
  logic               fire;
  out_word_t          res;

  out_word_t          ob_mem_r [2];
  logic               ob_wr_r, ob_wr_nxt;
  logic               ob_rd_r, ob_rd_nxt;
  logic [1:0]         ob_cnt_r, ob_cnt_nxt;
  logic               ob_pop;

  assign fire    = !mid_empty && (ob_cnt_r != 2'd2);
  assign mid_pop = fire;
  assign ot_x10  = thr.ot_x10;
  assign ut_x10  = thr.ut_x10;

  // saturating add for the pack total
  assign sum = {1'b0, tot_r} + (TOTAL_W+1)'(mid_word.mv);

  // statistics after this word
  always_comb begin
    tot_upd    = tot_r;
    min_mv_upd = min_mv_r;
    max_mv_upd = max_mv_r;
    min_t_upd  = min_t_r;
    max_t_upd  = max_t_r;
    unique case (mid_word.op)
      ACT_CLR_VOLT: begin
        tot_upd    = '0;
        min_mv_upd = MV_MIN_CLR;
        max_mv_upd = '0;
      end
      ACT_VOLT: begin
        if (mid_word.ok) begin
          tot_upd = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
          if (mid_word.mv < min_mv_r) begin
            min_mv_upd = mid_word.mv;
          end
          if (mid_word.mv > max_mv_r) begin
            max_mv_upd = mid_word.mv;
          end
        end
      end
      ACT_CLR_TEMP: begin
        min_t_upd = TEMP_MIN_CLR;
        max_t_upd = TEMP_MAX_CLR;
      end
      ACT_TEMP: begin
        if (mid_word.ok) begin
          if (mid_word.temp < min_t_r) begin
            min_t_upd = mid_word.temp;
          end
          if (mid_word.temp > max_t_r) begin
            max_t_upd = mid_word.temp;
          end
        end
      end
      default: begin
        tot_upd = tot_r;
      end
    endcase
  end

  assign tot_nxt    = fire ? tot_upd : tot_r;
  assign min_mv_nxt = fire ? min_mv_upd : min_mv_r;
  assign max_mv_nxt = fire ? max_mv_upd : max_mv_r;
  assign min_t_nxt  = fire ? min_t_upd : min_t_r;
  assign max_t_nxt  = fire ? max_t_upd : max_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r    <= '0;
      min_mv_r <= MV_MIN_CLR;
      max_mv_r <= '0;
      min_t_r  <= TEMP_MIN_CLR;
      max_t_r  <= TEMP_MAX_CLR;
    end else begin
      tot_r    <= tot_nxt;
      min_mv_r <= min_mv_nxt;
      max_mv_r <= max_mv_nxt;
      min_t_r  <= min_t_nxt;
      max_t_r  <= max_t_nxt;
    end
  end

  // result word with threshold flags on the updated statistics
  always_comb begin
    res.cell_mv             = mid_word.mv;
    res.sample_valid        = mid_word.ok;
    res.pack_total_mv       = 24'(tot_upd);
    res.lowest_cell_mv      = min_mv_upd;
    res.highest_cell_mv     = max_mv_upd;
    res.lowest_temp         = min_t_upd;
    res.highest_temp        = max_t_upd;
    res.over_voltage_fault  = max_mv_upd > thr.ov_mv;
    res.under_voltage_fault = (min_mv_upd < thr.uv_mv) && (min_mv_upd > MV_UV_FLOOR);
    res.over_temp_fault     = max_t_upd > ot_x10;
    res.under_temp_fault    = (min_t_upd < ut_x10) && (min_t_upd > TEMP_LO);
  end

  // two-word result buffer
  assign out_empty = (ob_cnt_r == 2'd0);
  assign out_word  = ob_mem_r[ob_rd_r];
  assign ob_pop    = out_pop && !out_empty;

  always_comb begin
    ob_wr_nxt  = fire ? ~ob_wr_r : ob_wr_r;
    ob_rd_nxt  = ob_pop ? ~ob_rd_r : ob_rd_r;
    ob_cnt_nxt = ob_cnt_r;
    if (fire && !ob_pop) begin
      ob_cnt_nxt = ob_cnt_r + 2'd1;
    end else if (ob_pop && !fire) begin
      ob_cnt_nxt = ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      ob_wr_r  <= ob_wr_nxt;
      ob_rd_r  <= ob_rd_nxt;
      ob_cnt_r <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ob_mem_r[ob_wr_r] <= res;
    end
  end

endmodule

// ----- sv/battery_pack_cell_monitor_core.sv -----
// top level of the battery pack cell monitor
//
// Input words (action, sample) are pushed with in_push and taken whenever
// in_full is low. Each word yields exactly one result word, read from the
// output queue: out_word is valid while out_empty is low and is removed
// with out_pop. Thresholds are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high and a write lands at the edge it is presented.
// A result passes, in order, the first-multiply register at the accepting
// edge, the second-multiply stage, the classified queue and the result
// buffer, which is written together with the statistics update.
// Throughput: one word per cycle, sustained, as long as results are popped;
// the constant multiplies and the statistics update are each one stage.
// If the consumer stops popping, the two-word result buffer, the four-word
// classified queue and the two front stages fill before in_full rises;
// nothing is dropped. Reset clears the scans (total 0, cell min 5000,
// max 0, temperature min 20000, max -20000), restores default thresholds
// and empties every queue.
module battery_pack_cell_monitor_core
  import bpcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_word_t              in_word,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic               mid_push, mid_full, mid_pop, mid_empty;
  mid_word_t          front_word, back_word;

  logic [12:0]        ov_mv_r, ov_mv_nxt;
  logic [12:0]        uv_mv_r, uv_mv_nxt;
  logic signed [15:0] ot_x10_r, ot_x10_nxt;
  logic signed [15:0] ut_x10_r, ut_x10_nxt;
  logic signed [15:0] deg_ext, deg_x10;
  thr_t               thr;

  assign cfg_ready = 1'b1;

  // whole degrees to tenths at write time
  assign deg_ext = {{7{cfg_data[8]}}, cfg_data[8:0]};
  assign deg_x10 = (deg_ext <<< 3) + (deg_ext <<< 1);

  // threshold register writes
  always_comb begin
    ov_mv_nxt  = ov_mv_r;
    uv_mv_nxt  = uv_mv_r;
    ot_x10_nxt = ot_x10_r;
    ut_x10_nxt = ut_x10_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OV_MV:  ov_mv_nxt  = cfg_data[12:0];
        CFG_UV_MV:  uv_mv_nxt  = cfg_data[12:0];
        CFG_OT_DEG: ot_x10_nxt = deg_x10;
        CFG_UT_DEG: ut_x10_nxt = deg_x10;
        default:    ov_mv_nxt  = ov_mv_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_mv_r  <= OV_MV_RST;
      uv_mv_r  <= UV_MV_RST;
      ot_x10_r <= OT_X10_RST;
      ut_x10_r <= UT_X10_RST;
    end else begin
      ov_mv_r  <= ov_mv_nxt;
      uv_mv_r  <= uv_mv_nxt;
      ot_x10_r <= ot_x10_nxt;
      ut_x10_r <= ut_x10_nxt;
    end
  end

  assign thr.ov_mv  = ov_mv_r;
  assign thr.uv_mv  = uv_mv_r;
  assign thr.ot_x10 = ot_x10_r;
  assign thr.ut_x10 = ut_x10_r;

  bpcm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_word  (in_word),
    .in_full  (in_full),
    .mid_push (mid_push),
    .mid_word (front_word),
    .mid_full (mid_full)
  );

  bpcm_fifo u_mid (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (front_word),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (back_word),
    .empty (mid_empty)
  );

  bpcm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_word  (back_word),
    .mid_pop   (mid_pop),
    .thr       (thr),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

// ----- sv/bpcm_port_chk.sv -----
// port-level checks for the cell monitor, bound to the top level
`include "battery_pack_cell_monitor_core_assert.svh"

module bpcm_port_chk
  import bpcm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_push,
  input in_word_t              in_word,
  input logic                  in_full,
  input logic                  out_empty,
  input logic                  out_pop,
  input out_word_t             out_word,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // a waiting result word holds until popped
  `BPCM_ASSERT_NXT(a_out_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_word))

  // input back-pressure only once results are backed up
  `BPCM_ASSERT_IMP(a_full_needs_result, clk, rst_n, in_full, !out_empty)

  // a valid cell lies inside the window and inside its scan bounds
  `BPCM_ASSERT_IMP(a_valid_cell, clk, rst_n, !out_empty && out_word.sample_valid && (out_word.cell_mv != 13'd0), (out_word.cell_mv >= MV_CELL_LO) && (out_word.cell_mv <= MV_CELL_HI) && (out_word.lowest_cell_mv <= out_word.cell_mv) && (out_word.highest_cell_mv >= out_word.cell_mv))

  // threshold writes are never held off
  `BPCM_ASSERT_IMP(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind battery_pack_cell_monitor_core bpcm_port_chk u_port_chk (.*);

// ----- verif/battery_pack_cell_monitor_core_tb.sv -----
// self-checking testbench for the battery pack cell monitor core
module battery_pack_cell_monitor_core_tb;
  import bpcm_pkg::*;

  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          PHASE_WORDS   = 220;
  localparam int          SCAN_CELLS    = 130;
  localparam int          CELL_LO_MV    = 1000;
  localparam int          CELL_HI_MV    = 5000;
  localparam int          TEMP_LO_X10   = -1000;
  localparam int          TEMP_HI_X10   = 2000;
  localparam int          UV_FLOOR      = 500;
  localparam logic [23:0] TOTAL_MAX     = 24'hFFFFFF;

  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_t;

  // running scan statistics and thresholds, expected result words in order
  class cell_scan_tracker;
    logic [12:0]        ov_mv;
    logic [12:0]        uv_mv;
    logic signed [8:0]  ot_deg;
    logic signed [8:0]  ut_deg;
    logic [23:0]        total_mv;
    logic [12:0]        min_mv;
    logic [12:0]        max_mv;
    logic signed [15:0] low_temp;
    logic signed [15:0] max_temp;
    out_word_t          expected_stats_q[$];
    int                 errors;

    function new();
      ov_mv    = 13'd4200;
      uv_mv    = 13'd3000;
      ot_deg   = 9'sd60;
      ut_deg   = 9'sd0;
      total_mv = '0;
      min_mv   = 13'd5000;
      max_mv   = '0;
      low_temp = 16'sd20000;
      max_temp = -16'sd20000;
      errors   = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_OV_MV:  ov_mv  = data[12:0];
        CFG_UV_MV:  uv_mv  = data[12:0];
        CFG_OT_DEG: ot_deg = data[8:0];
        CFG_UT_DEG: ut_deg = data[8:0];
        default: ;
      endcase
    endfunction

    // statistics after one word, with the fault flags on the new state
    function out_word_t predict_stats(in_word_t w);
      out_word_t r;
      int        code;
      int        mv;
      int        sum;
      r    = '0;
      code = $signed(w.sample);
      case (w.action)
        ACT_CLR_VOLT: begin
          total_mv = '0;
          min_mv   = 13'd5000;
          max_mv   = '0;
        end
        ACT_VOLT: begin
          // negative codes stay at zero millivolts
          if (code >= 0) begin
            mv        = int'((longint'(code) * 19073) / 100000);
            r.cell_mv = mv[12:0];
            if (mv >= CELL_LO_MV && mv <= CELL_HI_MV) begin
              r.sample_valid = 1'b1;
              sum = int'(total_mv) + mv;
              total_mv = (sum > int'(TOTAL_MAX)) ? TOTAL_MAX : sum[23:0];
              if (mv < int'(min_mv)) min_mv = mv[12:0];
              if (mv > int'(max_mv)) max_mv = mv[12:0];
            end
          end
        end
        ACT_CLR_TEMP: begin
          low_temp = 16'sd20000;
          max_temp = -16'sd20000;
        end
        ACT_TEMP: begin
          if (code >= TEMP_LO_X10 && code <= TEMP_HI_X10) begin
            r.sample_valid = 1'b1;
            if (code < int'(low_temp)) low_temp = code[15:0];
            if (code > int'(max_temp)) max_temp = code[15:0];
          end
        end
        default: ;
      endcase
      r.pack_total_mv       = total_mv;
      r.lowest_cell_mv      = min_mv;
      r.highest_cell_mv     = max_mv;
      r.lowest_temp         = low_temp;
      r.highest_temp        = max_temp;
      r.over_voltage_fault  = max_mv > ov_mv;
      r.under_voltage_fault = (min_mv < uv_mv) && (int'(min_mv) > UV_FLOOR);
      r.over_temp_fault     = int'(max_temp) > 10 * int'(ot_deg);
      r.under_temp_fault    = (int'(low_temp) < 10 * int'(ut_deg)) &&
                              (int'(low_temp) > TEMP_LO_X10);
      return r;
    endfunction

    function void note_word(in_word_t w);
      expected_stats_q.push_back(predict_stats(w));
    endfunction

    function void cmp_field(string name, logic signed [31:0] e, logic signed [31:0] g);
      if (g !== e) begin
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, e, g);
        errors++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      if (expected_stats_q.size() == 0) begin
        $display("%0t unexpected result word %h", $time, got);
        errors++;
        return;
      end
      e = expected_stats_q.pop_front();
      cmp_field("cell_mv", e.cell_mv, got.cell_mv);
      cmp_field("sample_valid", e.sample_valid, got.sample_valid);
      cmp_field("pack_total_mv", e.pack_total_mv, got.pack_total_mv);
      cmp_field("lowest_cell_mv", e.lowest_cell_mv, got.lowest_cell_mv);
      cmp_field("highest_cell_mv", e.highest_cell_mv, got.highest_cell_mv);
      cmp_field("lowest_temp", e.lowest_temp, got.lowest_temp);
      cmp_field("highest_temp", e.highest_temp, got.highest_temp);
      cmp_field("over_voltage_fault", e.over_voltage_fault, got.over_voltage_fault);
      cmp_field("under_voltage_fault", e.under_voltage_fault, got.under_voltage_fault);
      cmp_field("over_temp_fault", e.over_temp_fault, got.over_temp_fault);
      cmp_field("under_temp_fault", e.under_temp_fault, got.under_temp_fault);
    endfunction

    function int pending();
      return expected_stats_q.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_push   = 1'b0;
  in_word_t              in_word   = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop   = 1'b0;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_OV_MV;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  cell_scan_tracker stats = new();

  int          burst_left  = 1;
  int          hold_ticket = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  rx_style_t   rx_style    = RX_STREAM;
  int          rx_left     = 0;
  int unsigned rx_tick     = 0;
  int unsigned cycle_cnt   = 0;

  always #1 clk = ~clk;

  battery_pack_cell_monitor_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_word   (in_word),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // monitor both queue sides, then pick the next pop
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) stats.note_word(in_word);
      if (out_pop && !out_empty) stats.check_word(out_word);
    end
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (rx_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_left  = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    rx_tick++;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      case (rx_style)
        RX_STREAM: out_pop <= 1'b1;
        RX_COIN:   out_pop <= ($urandom_range(0, 1) != 0);
        RX_SPARSE: out_pop <= ($urandom_range(0, 9) == 0);
        default:   out_pop <= ((rx_tick % 5) < 2);
      endcase
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** battery_pack_cell_monitor_core: FAILED **");
      $finish;
    end
  end

  function automatic in_word_t make_word(action_t a, int s);
    in_word_t w;
    w.action = a;
    w.sample = s[15:0];
    return w;
  endfunction

  // mostly in-window samples, some out of window, some raw codes
  function automatic in_word_t rand_word();
    int      pick;
    int      s;
    action_t a;
    pick = $urandom_range(0, 99);
    if (pick < 4)       a = ACT_CLR_VOLT;
    else if (pick < 50) a = ACT_VOLT;
    else if (pick < 54) a = ACT_CLR_TEMP;
    else                a = ACT_TEMP;
    pick = $urandom_range(0, 9);
    if (a == ACT_VOLT) begin
      if (pick < 7)       s = $urandom_range(5244, 26220);
      else if (pick == 7) s = $urandom_range(0, 5243);
      else if (pick == 8) s = $urandom_range(26221, 32767);
      else                s = $urandom;
    end else begin
      if (pick < 8) s = $urandom_range(0, 3000) - 1000;
      else          s = $urandom;
    end
    return make_word(a, s);
  endfunction

  task automatic push_word(input in_word_t w);
    in_push <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      in_push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // push in bursts of random length with random gaps in between
  task automatic push_paced(input in_word_t w);
    push_word(w);
    burst_left--;
    if (burst_left <= 0) begin
      idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic send_random(input int n);
    repeat (n) push_paced(rand_word());
  endtask

  // one edge first so the last accepted word is already noted
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (stats.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    stats.write_reg(idx, data);
  endtask

  // temperature thresholds go out sign extended to the data width
  task automatic write_thresholds(input int ov, input int uv, input int ot, input int ut);
    write_reg(CFG_OV_MV, ov[12:0]);
    write_reg(CFG_UV_MV, uv[12:0]);
    write_reg(CFG_OT_DEG, ot[12:0]);
    write_reg(CFG_UT_DEG, ut[12:0]);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_random_thresholds();
    write_thresholds($urandom_range(900, 5100), $urandom_range(900, 5100),
                     $urandom_range(0, 300) - 100, $urandom_range(0, 300) - 100);
  endtask

  initial begin
    int n_cells;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: conversion edges and window limits at reset thresholds
    push_paced(make_word(ACT_VOLT, 0));
    push_paced(make_word(ACT_VOLT, -32768));
    push_paced(make_word(ACT_VOLT, -1));
    push_paced(make_word(ACT_VOLT, 32767));
    push_paced(make_word(ACT_VOLT, 5243));
    push_paced(make_word(ACT_VOLT, 5244));
    push_paced(make_word(ACT_VOLT, 26220));
    push_paced(make_word(ACT_VOLT, 26221));
    push_paced(make_word(ACT_VOLT, 15000));
    push_paced(make_word(ACT_VOLT, 23000));
    push_paced(make_word(ACT_CLR_VOLT, 0));
    push_paced(make_word(ACT_VOLT, 15000));
    push_paced(make_word(ACT_TEMP, -1001));
    push_paced(make_word(ACT_TEMP, 2001));
    push_paced(make_word(ACT_TEMP, -32768));
    push_paced(make_word(ACT_TEMP, 32767));
    push_paced(make_word(ACT_TEMP, 650));
    push_paced(make_word(ACT_TEMP, -50));
    push_paced(make_word(ACT_TEMP, -1000));
    push_paced(make_word(ACT_TEMP, 2000));
    push_paced(make_word(ACT_CLR_TEMP, -1));
    push_paced(make_word(ACT_TEMP, 0));
    push_paced(make_word(ACT_CLR_TEMP, 0));
    push_paced(make_word(ACT_CLR_VOLT, -1));
    send_random(PHASE_WORDS);
    wait_drained();

    // threshold extremes: every fault easy to raise
    write_thresholds(0, 8191, -100, 200);
    send_random(PHASE_WORDS);
    wait_drained();

    // threshold extremes: faults hard to raise
    write_thresholds(8191, 0, 200, -100);
    send_random(PHASE_WORDS);
    wait_drained();

    // receiver holds off while the sender keeps pushing, block fills up
    hold_ticket <= hold_ticket + 1;
    repeat (80) push_word(rand_word());
    wait_drained();

    repeat (2) begin
      write_random_thresholds();
      send_random(PHASE_WORDS);
      wait_drained();
    end

    // one long scan of full-scale cells for a large pack total
    write_thresholds(4999, $urandom_range(900, 5100),
                     $urandom_range(0, 300) - 100, $urandom_range(0, 300) - 100);
    push_paced(make_word(ACT_CLR_VOLT, 0));
    n_cells = 0;
    while (n_cells < SCAN_CELLS) begin
      if ($urandom_range(0, 9) == 0) begin
        push_paced(make_word(ACT_TEMP, $urandom_range(0, 3000) - 1000));
      end else begin
        push_paced(make_word(ACT_VOLT, $urandom_range(26216, 26220)));
        n_cells++;
      end
    end
    push_paced(make_word(ACT_CLR_VOLT, 0));
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (stats.errors == 0 && stats.pending() == 0) begin
      $display("** battery_pack_cell_monitor_core: PASSED **");
    end else begin
      $display("** battery_pack_cell_monitor_core: FAILED **");
    end
    $finish;
  end

endmodule
